@@ rtl/core/rmie_pkg.sv @@
// Package for the RAM machine instruction executor: beat structs, opcodes,
// addressing modes, error codes and controller/datapath command and status.
// No dependencies.
package rmie_pkg;

  typedef struct packed {
    logic [3:0]         op;
    logic [1:0]         mode;
    logic signed [31:0] operand;
    logic signed [31:0] tape_value;
  } item_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic               halted;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic [1:0]         error;
  } result_t;

  localparam logic [3:0] OP_LOAD  = 4'd0;
  localparam logic [3:0] OP_STORE = 4'd1;
  localparam logic [3:0] OP_READ  = 4'd2;
  localparam logic [3:0] OP_WRITE = 4'd3;
  localparam logic [3:0] OP_ADD   = 4'd4;
  localparam logic [3:0] OP_SUB   = 4'd5;
  localparam logic [3:0] OP_MUL   = 4'd6;
  localparam logic [3:0] OP_DIV   = 4'd7;
  localparam logic [3:0] OP_HALT  = 4'd8;
  localparam logic [3:0] OP_JUMP  = 4'd9;
  localparam logic [3:0] OP_JGZT  = 4'd10;
  localparam logic [3:0] OP_JZERO = 4'd11;

  localparam logic [1:0] MODE_IMM = 2'd0;
  localparam logic [1:0] MODE_DIR = 2'd1;
  localparam logic [1:0] MODE_IND = 2'd2;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_DIV0  = 2'd1;
  localparam logic [1:0] ERR_ADDR  = 2'd2;
  localparam logic [1:0] ERR_STIMM = 2'd3;

  typedef struct packed {
    logic clear;
    logic capture;
    logic rd_opnd;
    logic chk_ptr;
    logic ar_start;
    logic ar_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mem_need;
    logic is_ar;
    logic ar_last;
    logic out_busy;
  } stat_t;

endpackage

@@ rtl/core/rmie_ctrl.sv @@
// Controller state machine of the RAM machine instruction executor.
// Depends on rmie_pkg (cmd_t, stat_t).
module rmie_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  rmie_pkg::stat_t stat,
  output rmie_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_PTR  = 3'd3;
  localparam logic [2:0] S_EXE  = 3'd4;
  localparam logic [2:0] S_AR   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.mem_need) begin
          cmd.rd_opnd = 1'b1;
          state_next  = S_PTR;
        end else begin
          state_next = S_EXE;
        end
      end
      S_PTR: begin
        cmd.chk_ptr = 1'b1;
        state_next  = S_EXE;
      end
      S_EXE: begin
        if (stat.is_ar) begin
          cmd.ar_start = 1'b1;
          state_next   = S_AR;
        end else begin
          state_next = S_FIN;
        end
      end
      S_AR: begin
        cmd.ar_step = 1'b1;
        if (stat.ar_last) state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/rmie_datapath.sv @@
// Datapath of the RAM machine instruction executor: register file memory,
// accumulator, counter, shift-add multiply / restoring divide, result register.
// Depends on rmie_pkg.
module rmie_datapath #(
  parameter int NUM_REGS   = 256,
  parameter int PROG_DEPTH = 1024,
  parameter int WORD_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  rmie_pkg::item_t   item,
  input  rmie_pkg::cmd_t    cmd,
  output rmie_pkg::stat_t   stat,
  output logic              result_valid,
  input  logic              result_ready,
  output rmie_pkg::result_t result
);

  localparam int IW   = $clog2(NUM_REGS);
  localparam int PW   = $clog2(PROG_DEPTH);
  localparam int WB   = WORD_BITS;
  localparam int CNTW = $clog2(WB);
  localparam int CW   = (WB > 18) ? WB : 18;

  logic [WB-1:0] mem [NUM_REGS];
  logic [WB-1:0] rdata;

  rmie_pkg::item_t it;
  logic [WB-1:0]   acc;
  logic [PW-1:0]   pc;
  logic [IW-1:0]   clr_cnt;
  logic [IW-1:0]   ptr_idx;
  logic            ptr_bad;
  logic [WB-1:0]   ar_a, ar_b;
  logic [WB:0]     ar_r;
  logic [CNTW-1:0] ar_cnt;
  logic            ar_neg;

  logic          is_fetch, is_store, is_mem, opnd_bad, take, tgt_bad;
  logic [1:0]    err_pre, err;
  logic [WB-1:0] imm, tapew, v, v_abs, acc_abs, ar_res, acc_new;
  logic [WB:0]   div_t;
  logic [IW-1:0] opnd_idx, st_idx, raddr, waddr;
  logic          rd_en, wen, acc_wr;
  logic [WB-1:0] wdata;
  logic [PW-1:0] pc_inc, pc_next;

  always_comb begin
    imm      = WB'($signed(it.operand));
    tapew    = WB'($signed(it.tape_value));
    opnd_idx = IW'(it.operand);
    opnd_bad = it.operand[31] || (32'(it.operand) >= 32'(NUM_REGS));
    is_fetch = (it.op == rmie_pkg::OP_LOAD) || (it.op == rmie_pkg::OP_WRITE) ||
               (it.op == rmie_pkg::OP_ADD)  || (it.op == rmie_pkg::OP_SUB)   ||
               (it.op == rmie_pkg::OP_MUL)  || (it.op == rmie_pkg::OP_DIV);
    is_store = (it.op == rmie_pkg::OP_STORE) || (it.op == rmie_pkg::OP_READ);
    is_mem   = is_fetch || is_store;
    err_pre  = rmie_pkg::ERR_OK;
    if (is_mem) begin
      if (it.mode == rmie_pkg::MODE_IMM) begin
        if (is_store) err_pre = rmie_pkg::ERR_STIMM;
      end else if (it.mode != rmie_pkg::MODE_DIR && it.mode != rmie_pkg::MODE_IND) begin
        err_pre = rmie_pkg::ERR_ADDR;
      end else if (opnd_bad) begin
        err_pre = rmie_pkg::ERR_ADDR;
      end else if (it.mode == rmie_pkg::MODE_IND && ptr_bad) begin
        err_pre = rmie_pkg::ERR_ADDR;
      end
    end
    err = err_pre;
    if (it.op == rmie_pkg::OP_DIV && err_pre == rmie_pkg::ERR_OK && acc == '0)
      err = rmie_pkg::ERR_DIV0;
    v       = (it.mode == rmie_pkg::MODE_IMM) ? imm : rdata;
    v_abs   = v[WB-1] ? (~v + 1'b1) : v;
    acc_abs = acc[WB-1] ? (~acc + 1'b1) : acc;
    st_idx  = (it.mode == rmie_pkg::MODE_IND) ? ptr_idx : opnd_idx;
    div_t   = {ar_r[WB-1:0], ar_a[WB-1]};
    ar_res  = (it.op == rmie_pkg::OP_MUL) ? ar_r[WB-1:0] :
              (ar_neg ? (~ar_a + 1'b1) : ar_a);

    take = 1'b0;
    case (it.op)
      rmie_pkg::OP_JUMP:  take = 1'b1;
      rmie_pkg::OP_JGZT:  take = (acc != '0) && !acc[WB-1];
      rmie_pkg::OP_JZERO: take = (acc == '0);
      default:            take = 1'b0;
    endcase
    tgt_bad = it.operand[31] || (32'(it.operand) >= 32'(PROG_DEPTH));
    pc_inc  = (pc == PW'(PROG_DEPTH - 1)) ? '0 : pc + 1'b1;
    pc_next = pc_inc;
    if (it.op == rmie_pkg::OP_HALT) pc_next = pc;
    else if (take && !tgt_bad)      pc_next = PW'(it.operand);

    acc_wr  = 1'b0;
    acc_new = v;
    case (it.op)
      rmie_pkg::OP_LOAD: begin acc_wr = 1'b1; acc_new = v; end
      rmie_pkg::OP_ADD:  begin acc_wr = 1'b1; acc_new = v + acc; end
      rmie_pkg::OP_SUB:  begin acc_wr = 1'b1; acc_new = v - acc; end
      rmie_pkg::OP_MUL:  begin acc_wr = 1'b1; acc_new = ar_res; end
      rmie_pkg::OP_DIV:  begin acc_wr = 1'b1; acc_new = ar_res; end
      default:           acc_wr = 1'b0;
    endcase
    if (err != rmie_pkg::ERR_OK) acc_wr = 1'b0;

    wen   = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    if (cmd.clear) begin
      wen = 1'b1;
    end else if (cmd.finish && err == rmie_pkg::ERR_OK) begin
      if (acc_wr) begin
        wen = 1'b1; waddr = '0; wdata = acc_new;
      end else if (is_store) begin
        wen   = 1'b1;
        waddr = st_idx;
        wdata = (it.op == rmie_pkg::OP_STORE) ? acc : tapew;
      end
    end

    rd_en = cmd.rd_opnd || (cmd.chk_ptr && it.mode == rmie_pkg::MODE_IND);
    raddr = cmd.rd_opnd ? opnd_idx : IW'(rdata);

    stat.clr_last = (clr_cnt == IW'(NUM_REGS - 1));
    stat.mem_need = is_mem && !opnd_bad &&
                    (it.mode == rmie_pkg::MODE_DIR || it.mode == rmie_pkg::MODE_IND);
    stat.is_ar    = (it.op == rmie_pkg::OP_MUL || it.op == rmie_pkg::OP_DIV) &&
                    err == rmie_pkg::ERR_OK;
    stat.ar_last  = (ar_cnt == CNTW'(WB - 1));
    stat.out_busy = result_valid && !result_ready;
  end

  always_ff @(posedge clk) begin
    if (wen)   mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it      <= item;
      ptr_bad <= 1'b0;
    end
    if (cmd.chk_ptr && it.mode == rmie_pkg::MODE_IND) begin
      ptr_bad <= rdata[WB-1] || (CW'(rdata) >= CW'(NUM_REGS));
      ptr_idx <= IW'(rdata);
    end
    if (cmd.ar_start) begin
      ar_cnt <= '0;
      ar_r   <= '0;
      ar_neg <= v[WB-1] ^ acc[WB-1];
      if (it.op == rmie_pkg::OP_MUL) begin
        ar_a <= v;
        ar_b <= acc;
      end else begin
        ar_a <= v_abs;
        ar_b <= acc_abs;
      end
    end else if (cmd.ar_step) begin
      ar_cnt <= ar_cnt + 1'b1;
      if (it.op == rmie_pkg::OP_MUL) begin
        if (ar_b[0]) ar_r <= {1'b0, ar_r[WB-1:0] + ar_a};
        ar_a <= ar_a << 1;
        ar_b <= ar_b >> 1;
      end else begin
        if (div_t >= {1'b0, ar_b}) begin
          ar_r <= div_t - {1'b0, ar_b};
          ar_a <= {ar_a[WB-2:0], 1'b1};
        end else begin
          ar_r <= div_t;
          ar_a <= {ar_a[WB-2:0], 1'b0};
        end
      end
    end
    if (cmd.finish) begin
      result.next_pc   <= 10'(pc_next);
      result.halted    <= (it.op == rmie_pkg::OP_HALT);
      result.error     <= (take && tgt_bad) ? rmie_pkg::ERR_ADDR : err;
      result.out_valid <= (it.op == rmie_pkg::OP_WRITE) && err == rmie_pkg::ERR_OK;
      result.out_value <= ((it.op == rmie_pkg::OP_WRITE) && err == rmie_pkg::ERR_OK) ?
                          32'($signed(v)) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      pc           <= '0;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.finish) begin
        pc <= pc_next;
        if (wen && waddr == '0) acc <= wdata;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(result_valid && !result_ready))
    else $error("result overwritten while held");
  a_ar_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.ar_start |=> ar_cnt == '0)
    else $error("arith counter not restarted");
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_valid |-> result.out_value == '0)
    else $error("out_value set without write");
  a_err_no_out: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error != rmie_pkg::ERR_OK |-> !result.out_valid)
    else $error("output emitted on error");
`endif

endmodule

@@ rtl/core/ram_machine_instruction_executor.sv @@
// RAM machine instruction executor, top level: controller plus datapath.
// Sequence: accept, decode, a register read step when a register is read
// (direct or indirect), execute, MUL/DIV iteration, then finish and result.
// Throughput: one instruction at a time, accepted again the cycle after finish.
// Reset: synchronous; clears counter and accumulator, then sweeps the register
// file to zero, during which no instruction is accepted.
module ram_machine_instruction_executor #(
  parameter int NUM_REGS   = 256,
  parameter int PROG_DEPTH = 1024,
  parameter int WORD_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rmie_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output rmie_pkg::result_t result
);

  rmie_pkg::cmd_t  cmd;
  rmie_pkg::stat_t stat;

  rmie_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rmie_datapath #(
    .NUM_REGS   (NUM_REGS),
    .PROG_DEPTH (PROG_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
